FILE: rtl/core/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants for the escaped frame receiver
// Register codes, field widths and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

  // Payload store depth and field widths
  localparam int PAYLOAD_DEPTH = 64;
  localparam int ADDR_W        = 6;   // byte_index width
  localparam int CNT_W         = 7;   // byte count / frame_length width
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CODE  = 3'd0,
    REG_END_CODE    = 3'd1,
    REG_ESCAPE_CODE = 3'd2,
    REG_DEBUG_TYPE  = 3'd3,
    REG_MAX_PAYLOAD = 3'd4
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd192;
  localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'd193;
  localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd125;
  localparam logic [BYTE_W-1:0] DEBUG_TYPE_RST  = 8'd0;
  localparam logic [CNT_W-1:0]  MAX_PAYLOAD_RST = 7'd64;

  // Controller -> datapath commands (each valid for one cycle)
  typedef struct packed {
    logic store;        // keep the received byte if capacity allows
    logic set_type;     // received byte is the frame type
    logic clear_count;  // restart payload
    logic close_frame;  // latch frame info for readout, clear count
    logic rd_issue;     // read payload store at the readout index
    logic rd_advance;   // step the readout index
  } efr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic esc_hit;      // received byte matches escape_code
    logic start_hit;    // received byte matches start_code
    logic end_hit;      // received byte matches end_code
    logic count_zero;   // no payload kept in the current frame
    logic last_beat;    // readout index is the final payload byte
  } efr_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/efr_rx_if.sv
// ----------------------------------------------------------------------------
// efr_rx_if: received byte channel
// One byte per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface efr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/efr_frame_if.sv
// ----------------------------------------------------------------------------
// efr_frame_if: deframed payload channel
// One payload byte with its frame information per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface efr_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_type;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [5:0] byte_index;
  logic [6:0] frame_length;
  logic       is_debug;
  logic       last;

  modport source (output valid, output frame_type, output data_byte, output byte_valid,
                  output byte_index, output frame_length, output is_debug, output last,
                  input ready);
  modport sink   (input valid, input frame_type, input data_byte, input byte_valid,
                  input byte_index, input frame_length, input is_debug, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/efr_cfg_if.sv
// ----------------------------------------------------------------------------
// efr_cfg_if: configuration write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface efr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/efr_datapath.sv
// ----------------------------------------------------------------------------
// efr_datapath: configuration, payload store and readout registers
// Compares received bytes against the codes, keeps payload bytes up to the
// frame capacity and walks the store on readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efr_datapath
  import efr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // config writes
  input  wire logic              cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_data,
  // received byte
  input  wire logic [BYTE_W-1:0] rx_byte,
  // control
  input  wire efr_cmd_t          cmd,
  output efr_status_t            status,
  // result payload
  output logic [BYTE_W-1:0]      frame_type,
  output logic [BYTE_W-1:0]      data_byte,
  output logic                   byte_valid,
  output logic [ADDR_W-1:0]      byte_index,
  output logic [CNT_W-1:0]       frame_length,
  output logic                   is_debug
);

  // Configuration registers
  logic [BYTE_W-1:0] start_code;
  logic [BYTE_W-1:0] end_code;
  logic [BYTE_W-1:0] escape_code;
  logic [BYTE_W-1:0] debug_type;
  logic [CNT_W-1:0]  max_payload;

  // Frame state
  logic [BYTE_W-1:0] current_type;
  logic [CNT_W-1:0]  byte_count;

  // Readout registers
  logic [BYTE_W-1:0] out_type;
  logic [CNT_W-1:0]  out_len;
  logic              out_dbg;
  logic [ADDR_W-1:0] rd_idx;
  logic [BYTE_W-1:0] rd_data;

  logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];

  logic [CNT_W-1:0]  cap_limit;
  logic [CNT_W-1:0]  capacity;
  logic              can_store;
  logic [CNT_W-1:0]  rd_pos;

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_code  <= START_CODE_RST;
      end_code    <= END_CODE_RST;
      escape_code <= ESCAPE_CODE_RST;
      debug_type  <= DEBUG_TYPE_RST;
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_CODE:  start_code  <= cfg_data;
        REG_END_CODE:    end_code    <= cfg_data;
        REG_ESCAPE_CODE: escape_code <= cfg_data;
        REG_DEBUG_TYPE:  debug_type  <= cfg_data;
        REG_MAX_PAYLOAD: max_payload <= cfg_data[CNT_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // Capacity: full store for the debug type, else max_payload clamped
  always_comb begin
    cap_limit = (max_payload > CNT_W'(PAYLOAD_DEPTH)) ? CNT_W'(PAYLOAD_DEPTH) : max_payload;
    capacity  = (current_type == debug_type) ? CNT_W'(PAYLOAD_DEPTH) : cap_limit;
    can_store = byte_count < capacity;
  end

  // Frame type and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      current_type <= '0;
      byte_count   <= '0;
    end else begin
      if (cmd.set_type) begin
        current_type <= rx_byte;
      end
      if (cmd.clear_count || cmd.close_frame) begin
        byte_count <= '0;
      end else if (cmd.store && can_store) begin
        byte_count <= byte_count + CNT_W'(1);
      end
    end
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store && can_store) begin
      payload_mem[byte_count[ADDR_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= payload_mem[rd_idx];
    end
  end

  // Frame info latched at END, readout index
  always_ff @(posedge clk) begin
    if (cmd.close_frame) begin
      out_type <= current_type;
      out_len  <= byte_count;
      out_dbg  <= (current_type == debug_type);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.close_frame) begin
      rd_idx <= '0;
    end else if (cmd.rd_advance) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  assign rd_pos = {1'b0, rd_idx} + CNT_W'(1);

  // Status back to the controller
  always_comb begin
    status.esc_hit    = (rx_byte == escape_code);
    status.start_hit  = (rx_byte == start_code);
    status.end_hit    = (rx_byte == end_code);
    status.count_zero = (byte_count == '0);
    status.last_beat  = (rd_pos >= out_len);
  end

  // Result fields
  always_comb begin
    frame_type   = out_type;
    byte_valid   = (out_len != '0);
    data_byte    = byte_valid ? rd_data : '0;
    byte_index   = rd_idx;
    frame_length = out_len;
    is_debug     = out_dbg;
  end

endmodule

`default_nettype wire

FILE: rtl/core/efr_ctrl.sv
// ----------------------------------------------------------------------------
// efr_ctrl: deframing controller
// Tracks frame/escape/type flags per received byte and sequences the
// payload readout at END.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efr_ctrl
  import efr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire efr_status_t status,
  output efr_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t state, state_next;

  logic in_frame, in_frame_next;
  logic awaiting_type, awaiting_type_next;
  logic escape_pending, escape_pending_next;
  logic in_beat;
  logic out_beat;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;

  // Byte decode and readout sequencing
  always_comb begin
    state_next          = state;
    in_frame_next       = in_frame;
    awaiting_type_next  = awaiting_type;
    escape_pending_next = escape_pending;
    cmd                 = '0;

    unique case (state)
      S_IDLE: begin
        if (in_beat) begin
          priority if (escape_pending) begin
            escape_pending_next = 1'b0;
            cmd.store           = in_frame;
          end else if (status.esc_hit) begin
            escape_pending_next = 1'b1;
          end else if (status.start_hit) begin
            in_frame_next      = 1'b1;
            awaiting_type_next = 1'b1;
            cmd.clear_count    = 1'b1;
          end else if (status.end_hit) begin
            // END outside a frame is dropped
            if (in_frame) begin
              in_frame_next      = 1'b0;
              awaiting_type_next = 1'b0;
              cmd.close_frame    = 1'b1;
              state_next         = status.count_zero ? S_SEND : S_READ;
            end
          end else if (awaiting_type) begin
            awaiting_type_next = 1'b0;
            cmd.set_type       = 1'b1;
          end else begin
            cmd.store = in_frame;
          end
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_SEND;
      end
      S_SEND: begin
        if (out_beat) begin
          if (status.last_beat) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_advance = 1'b1;
            state_next     = S_READ;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      in_frame       <= 1'b0;
      awaiting_type  <= 1'b0;
      escape_pending <= 1'b0;
    end else begin
      state          <= state_next;
      in_frame       <= in_frame_next;
      awaiting_type  <= awaiting_type_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/escaped_frame_receiver.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver: byte-stuffed frame deframer with a type byte
// Recovers START/type/payload/END frames with escaping and emits the kept
// payload one byte per beat with frame type, length and debug flag.
//
//   port   dir   beat carries
//   rx     in    rx_byte
//   frame  out   frame_type, data_byte, byte_valid, byte_index,
//                frame_length, is_debug, last
//   cfg    in    index, data (register write)
//
// A byte that closes no frame is taken at once. END of a frame with kept
// bytes reads them out, a store read then a result beat for each; an empty
// frame gets a single result beat. The single read port of the payload
// store sets that. rx is not taken during the readout. A result waits in
// place while frame.ready is low. Reset restores the register defaults and
// clears the frame flags; the payload store needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_receiver
  import efr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  efr_rx_if.sink      rx,
  efr_frame_if.source frame,
  efr_cfg_if.sink     cfg
);

  efr_cmd_t    cmd;
  efr_status_t status;

  // Config port is always ready
  assign cfg.ready = 1'b1;

  efr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .status    (status),
    .cmd       (cmd)
  );

  efr_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .rx_byte      (rx.rx_byte),
    .cmd          (cmd),
    .status       (status),
    .frame_type   (frame.frame_type),
    .data_byte    (frame.data_byte),
    .byte_valid   (frame.byte_valid),
    .byte_index   (frame.byte_index),
    .frame_length (frame.frame_length),
    .is_debug     (frame.is_debug)
  );

  assign frame.last = status.last_beat;

endmodule

`default_nettype wire

FILE: rtl/core/efr_checker.sv
// ----------------------------------------------------------------------------
// efr_checker: port-level checks for the escaped frame receiver
// Watches the rx and frame channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] data_byte,
  input wire logic       byte_valid,
  input wire logic [5:0] byte_index,
  input wire logic [6:0] frame_length,
  input wire logic       last
);

  // No new byte is taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && rx_ready))
    else $error("rx ready while a result is pending");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // An empty frame is a single final beat with zeroed fields
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |->
      (last && frame_length == 7'd0 && byte_index == 6'd0 && data_byte == 8'd0))
    else $error("malformed empty frame beat");

  // Payload beats stay within the frame and last marks the final one
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid) |->
      ({1'b0, byte_index} < frame_length &&
       last == ({1'b0, byte_index} + 7'd1 == frame_length)))
    else $error("byte index or last out of step with frame length");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(data_byte) && $stable(byte_index)))
    else $error("result changed while stalled");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_ready     (rx.ready),
  .out_valid    (frame.valid),
  .out_ready    (frame.ready),
  .data_byte    (frame.data_byte),
  .byte_valid   (frame.byte_valid),
  .byte_index   (frame.byte_index),
  .frame_length (frame.frame_length),
  .last         (frame.last)
);

`default_nettype wire

FILE: bench/tb_escaped_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_escaped_frame_receiver: self-checking bench for the frame deframer
// Feeds byte-stuffed traffic on rx, predicts every payload beat in a small
// scoreboard and checks each beat taken on the frame port in order. A short
// directed warmup covers escapes, empty frames, restarts and code overlap;
// random phases follow, each under a new register setting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] frame_type;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [5:0] byte_index;
  logic [6:0] frame_length;
  logic       is_debug;
  logic       last;
} frame_beat_t;

// Predicts deframed beats and checks the ones the block sends out
class frame_scoreboard;
  logic [7:0]  start_code, end_code, escape_code, debug_type;
  logic [6:0]  max_payload;
  bit          in_frame, awaiting_type, escape_pending;
  int unsigned kept;
  logic [7:0]  frame_kind;
  logic [7:0]  payload [64];
  frame_beat_t pending_beats [$];
  int unsigned mismatches;

  function new();
    start_code     = efr_pkg::START_CODE_RST;
    end_code       = efr_pkg::END_CODE_RST;
    escape_code    = efr_pkg::ESCAPE_CODE_RST;
    debug_type     = efr_pkg::DEBUG_TYPE_RST;
    max_payload    = efr_pkg::MAX_PAYLOAD_RST;
    in_frame       = 1'b0;
    awaiting_type  = 1'b0;
    escape_pending = 1'b0;
    kept           = 0;
    frame_kind     = 8'h00;
    mismatches     = 0;
  endfunction

  function void write_reg(efr_pkg::cfg_reg_e idx, logic [7:0] value);
    case (idx)
      efr_pkg::REG_START_CODE:  start_code  = value;
      efr_pkg::REG_END_CODE:    end_code    = value;
      efr_pkg::REG_ESCAPE_CODE: escape_code = value;
      efr_pkg::REG_DEBUG_TYPE:  debug_type  = value;
      efr_pkg::REG_MAX_PAYLOAD: max_payload = value[6:0];
      default: ;
    endcase
  endfunction

  // Room follows the type as it stands; debug frames get the whole store
  function void keep_byte(logic [7:0] value);
    int unsigned room;
    room = (frame_kind == debug_type) ? efr_pkg::PAYLOAD_DEPTH : max_payload;
    if (room > efr_pkg::PAYLOAD_DEPTH) room = efr_pkg::PAYLOAD_DEPTH;
    if (kept < room) begin
      payload[kept] = value;
      kept++;
    end
  endfunction

  // One received byte; END of an open frame queues its beats
  function void note_rx(logic [7:0] value);
    frame_beat_t beat;
    logic        dbg;
    if (escape_pending) begin
      escape_pending = 1'b0;
      if (in_frame) keep_byte(value);
    end else if (value == escape_code) begin
      escape_pending = 1'b1;
    end else if (value == start_code) begin
      in_frame      = 1'b1;
      awaiting_type = 1'b1;
      kept          = 0;
    end else if (value == end_code) begin
      if (in_frame) begin
        dbg = (frame_kind == debug_type);
        if (kept == 0) begin
          beat = '{frame_type: frame_kind, data_byte: 8'h00, byte_valid: 1'b0,
                   byte_index: 6'd0, frame_length: 7'd0, is_debug: dbg, last: 1'b1};
          pending_beats.push_back(beat);
        end else begin
          for (int k = 0; k < kept; k++) begin
            beat = '{frame_type: frame_kind, data_byte: payload[k], byte_valid: 1'b1,
                     byte_index: 6'(k), frame_length: 7'(kept), is_debug: dbg,
                     last: (k + 1 == kept)};
            pending_beats.push_back(beat);
          end
        end
        in_frame      = 1'b0;
        awaiting_type = 1'b0;
        kept          = 0;
      end
    end else if (awaiting_type) begin
      frame_kind    = value;
      awaiting_type = 1'b0;
    end else if (in_frame) begin
      keep_byte(value);
    end
  endfunction

  function void check_beat(frame_beat_t got);
    frame_beat_t want;
    if (pending_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected frame beat: type=%h data=%h vld=%b idx=%0d len=%0d dbg=%b last=%b",
                 got.frame_type, got.data_byte, got.byte_valid, got.byte_index,
                 got.frame_length, got.is_debug, got.last);
      return;
    end
    want = pending_beats.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("frame beat mismatch: exp type=%h data=%h vld=%b idx=%0d len=%0d dbg=%b last=%b",
                 want.frame_type, want.data_byte, want.byte_valid, want.byte_index,
                 want.frame_length, want.is_debug, want.last);
        $display("                     got type=%h data=%h vld=%b idx=%0d len=%0d dbg=%b last=%b",
                 got.frame_type, got.data_byte, got.byte_valid, got.byte_index,
                 got.frame_length, got.is_debug, got.last);
      end
    end
  endfunction

  function int unsigned pending();
    return pending_beats.size();
  endfunction
endclass

module tb_escaped_frame_receiver;
  import efr_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 4;    // non-END bytes need no readout
  localparam int DRAIN_CYCLES = 20;

  logic            clk;
  logic            rst;
  bit              steady;            // no idling on either side
  int unsigned     rx_count;
  int unsigned     cycle_cnt;
  frame_scoreboard sb = new();

  efr_rx_if    rx_ch ();
  efr_frame_if frame_ch ();
  efr_cfg_if   cfg_ch ();

  escaped_frame_receiver u_top (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .frame (frame_ch),
    .cfg   (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random backpressure, check every accepted beat
  initial begin
    frame_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      frame_ch.ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_ch.valid && frame_ch.ready)
      sb.check_beat(frame_beat_t'({frame_ch.frame_type, frame_ch.data_byte,
                                   frame_ch.byte_valid, frame_ch.byte_index,
                                   frame_ch.frame_length, frame_ch.is_debug,
                                   frame_ch.last}));
  end

  // All tasks start and end at a falling edge. valid stays high on exit so
  // back-to-back beats need no second assignment in one step.
  task automatic send_byte(input logic [7:0] value);
    while (!steady && $urandom_range(99) < 15) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= value;
    do @(posedge clk); while (!rx_ch.ready);
    sb.note_rx(value);
    rx_count++;
    @(negedge clk);
  endtask

  // Hold rx until every predicted beat is out
  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] s_code, input logic [7:0] e_code,
                            input logic [7:0] x_code, input logic [7:0] d_type,
                            input logic [6:0] m_len);
    cfg_reg_e   regs [5];
    logic [7:0] vals [5];
    regs = '{REG_START_CODE, REG_END_CODE, REG_ESCAPE_CODE, REG_DEBUG_TYPE, REG_MAX_PAYLOAD};
    vals = '{s_code, e_code, x_code, d_type, {1'b0, m_len}};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.write_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Payload bytes lean toward the codes so escaping gets exercised
  task automatic send_frame(input int unsigned len, input bit debug, input bit close);
    logic [7:0] kind;
    logic [7:0] value;
    if (debug) begin
      kind = sb.debug_type;
    end else begin
      do kind = 8'($urandom);
      while (kind == sb.debug_type || kind == sb.start_code ||
             kind == sb.end_code || kind == sb.escape_code);
    end
    send_byte(sb.start_code);
    send_byte(kind);
    repeat (len) begin
      case ($urandom_range(7))
        0:       value = sb.start_code;
        1:       value = sb.end_code;
        2:       value = sb.escape_code;
        default: value = 8'($urandom);
      endcase
      if (value == sb.start_code || value == sb.end_code || value == sb.escape_code)
        send_byte(sb.escape_code);
      send_byte(value);
    end
    if (close) send_byte(sb.end_code);
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) begin
      case ($urandom_range(5))
        0:       send_byte(sb.start_code);
        1:       send_byte(sb.end_code);
        2:       send_byte(sb.escape_code);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // Mostly clean frames, some left open, some loose bytes
  task automatic run_phase(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = rx_count + n_bytes;
    while (rx_count < stop_at) begin
      pick = $urandom_range(99);
      len  = $urandom_range(0, 8);
      if (pick < 70)      send_frame(len, $urandom_range(3) == 0, 1'b1);
      else if (pick < 80) send_frame(len, $urandom_range(3) == 0, 1'b0);
      else                send_noise($urandom_range(1, 6));
      if ($urandom_range(9) == 0) drain();
    end
    drain();
  endtask

  initial begin : stimulus
    logic [7:0] warmup [$];
    logic [7:0] overlap [$];
    logic [7:0] s, e, x, d;
    logic [7:0] v;
    logic [6:0] m;

    rst            = 1'b1;
    steady         = 1'b0;
    rx_count       = 0;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = 8'h00;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_START_CODE;
    cfg_ch.data    = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset codes: stray END and escaped byte outside a frame, a debug frame
    // carrying escaped codes, an empty frame, END before the type, an
    // escaped byte before the type, and a restart by a second START.
    warmup = {END_CODE_RST, ESCAPE_CODE_RST, 8'h44,
              START_CODE_RST, DEBUG_TYPE_RST, 8'h00, 8'hFF,
              ESCAPE_CODE_RST, START_CODE_RST, ESCAPE_CODE_RST, END_CODE_RST,
              ESCAPE_CODE_RST, ESCAPE_CODE_RST, END_CODE_RST,
              START_CODE_RST, 8'hA5, END_CODE_RST,
              START_CODE_RST, END_CODE_RST,
              START_CODE_RST, ESCAPE_CODE_RST, 8'h33, 8'h5A,
              START_CODE_RST, 8'h5B, 8'h02, END_CODE_RST};
    foreach (warmup[i]) send_byte(warmup[i]);

    // START equal to END: the second FF restarts; capacity of one drops 22
    set_config(8'hFF, 8'hFF, 8'h00, 8'hFF, 7'd1);
    overlap = {8'hFF, 8'h10, 8'hFF, 8'h11, 8'h00, 8'hFF, 8'h22};
    foreach (overlap[i]) send_byte(overlap[i]);

    // Frame still open: new END closes it as debug; ESC outranks START
    set_config(8'h7F, 8'hFF, 8'h7F, 8'h11, 7'd0);
    overlap = {8'hFF, 8'h7F, 8'hFF};
    foreach (overlap[i]) send_byte(overlap[i]);

    // Random phases, each with fresh distinct codes
    for (int p = 0; p < 4; p++) begin
      do begin
        s = 8'($urandom);
        e = 8'($urandom);
        x = 8'($urandom);
        d = 8'($urandom);
        if (p == 3) begin
          s = 8'h00;
          e = 8'hFF;
          x = 8'h80;
        end
      end while (s == e || s == x || e == x || d == s || d == e || d == x);
      case (p)
        0:       m = 7'($urandom_range(1, 8));
        1:       m = 7'd64;
        2:       m = 7'd0;
        default: m = 7'($urandom_range(0, 64));
      endcase
      steady = (p == 1);
      set_config(s, e, x, d, m);
      if (p == 1) begin
        // One long frame of plain bytes offers more than the full store holds
        send_byte(s);
        do v = 8'($urandom); while (v == s || v == e || v == x || v == d);
        send_byte(v);
        repeat (66) begin
          do v = 8'($urandom); while (v == s || v == e || v == x);
          send_byte(v);
        end
        send_byte(e);
        drain();
      end else begin
        run_phase(6);
      end
    end
    steady = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: escaped_frame_receiver.f
rtl/core/efr_pkg.sv
rtl/core/efr_rx_if.sv
rtl/core/efr_frame_if.sv
rtl/core/efr_cfg_if.sv
rtl/core/efr_datapath.sv
rtl/core/efr_ctrl.sv
rtl/core/escaped_frame_receiver.sv
rtl/core/efr_checker.sv
bench/tb_escaped_frame_receiver.sv
